// ----- design/assert_macros.svh -----
// Assertion macros shared by the echo block.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every rising clock edge outside reset.
`define SFE_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// Condition never seen outside reset.
`define SFE_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("forbidden condition seen");

`endif

// ----- design/sfe_pkg.sv -----
// Package of the stereo echo block: field widths, register indexes and
// the control/status structs passed between its modules. No dependencies.
`default_nettype none

package sfe_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int GAIN_W    = 16;
    localparam int DELAY_W   = 17;
    localparam int FRAC_BITS = 12;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W    = SAMPLE_W + GAIN_W + 1;
    localparam int SUM_W     = PROD_W - FRAC_BITS + 1;

    localparam logic [CFG_IDX_W-1:0] REG_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 2'd1;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_TAIL   = 1'b1;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 17'd22050;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 16'd2048;

    // Control driven by the top level into each lane.
    typedef struct packed {
        logic en;      // whole pipeline advances
        logic load;    // input transfer this cycle: write the delay line
        logic active;  // echo term enabled for the item being loaded
    } t_lane_ctl;

    // Status of the output register and skid stage.
    typedef struct packed {
        logic out_v;
        logic skid_v;
    } t_out_stat;

endpackage

`default_nettype wire

// ----- design/sfe_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port
// (read-first on a same-address collision). No dependencies.
`default_nettype none

module sfe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- design/sfe_lane.sv -----
// One channel of the echo: delay-line RAM, gain multiply, add and saturate.
// Depends on sfe_pkg and sfe_ram.
`default_nettype none

module sfe_lane #(
    parameter int DEPTH = 65536
) (
    input  wire logic                          i_clk,
    input  wire sfe_pkg::t_lane_ctl            i_ctl,
    input  wire logic [$clog2(DEPTH)-1:0]      i_wr_addr,
    input  wire logic [$clog2(DEPTH)-1:0]      i_rd_addr,
    input  wire logic signed [sfe_pkg::SAMPLE_W-1:0] i_sample,
    input  wire logic [sfe_pkg::GAIN_W-1:0]    i_gain,
    output logic signed [sfe_pkg::SAMPLE_W-1:0] o_result
);
    import sfe_pkg::*;

    logic [SAMPLE_W-1:0]        ram_q;
    logic signed [SAMPLE_W-1:0] r_now1, r_now2;
    logic                       r_act1;
    logic signed [PROD_W-1:0]   prod_c;
    logic signed [PROD_W-1:0]   r_prod2;
    logic signed [SUM_W-1:0]    sum_c;

    sfe_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (i_ctl.load),
        .i_waddr (i_wr_addr),
        .i_wdata (i_sample),
        .i_re    (i_ctl.en),
        .i_raddr (i_rd_addr),
        .o_rdata (ram_q)
    );

    assign prod_c = $signed(ram_q) * $signed({1'b0, i_gain});

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_now1  <= i_sample;
            r_act1  <= i_ctl.active;
            r_now2  <= r_now1;
            r_prod2 <= r_act1 ? prod_c : '0;
        end
    end

    // arithmetic shift gives floor rounding
    assign sum_c = SUM_W'(r_now2) + SUM_W'($signed(r_prod2[PROD_W-1:FRAC_BITS]));

    always_comb begin
        if (sum_c > $signed(SUM_W'(32767))) begin
            o_result = 16'sh7FFF;
        end else if (sum_c < $signed(-SUM_W'(32768))) begin
            o_result = 16'sh8000;
        end else begin
            o_result = sum_c[SAMPLE_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ----- design/sfe_out.sv -----
// Merging stage: packs both lane results and holds them in an output
// register backed by a one-entry skid stage. Depends on sfe_pkg.
`default_nettype none

module sfe_out (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    input  wire logic [sfe_pkg::SAMPLE_W-1:0] i_left,
    input  wire logic [sfe_pkg::SAMPLE_W-1:0] i_right,
    input  wire logic                       i_tready,
    output logic                            o_tvalid,
    output logic [2*sfe_pkg::SAMPLE_W-1:0]  o_tdata,
    output sfe_pkg::t_out_stat              o_stat
);
    import sfe_pkg::*;

    logic                    r_out_v, r_skid_v;
    logic [2*SAMPLE_W-1:0]   r_out, r_skid;
    logic [2*SAMPLE_W-1:0]   merged;
    logic                    take;

    assign merged = {i_right, i_left};
    assign take   = r_out_v & i_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (i_push) begin
            if (!r_out_v || take) begin
                r_out_v <= 1'b1;
            end else begin
                r_skid_v <= 1'b1;
            end
        end else if (take) begin
            r_out_v  <= r_skid_v;
            r_skid_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            if (!r_out_v || take) begin
                r_out <= merged;
            end else begin
                r_skid <= merged;
            end
        end else if (take && r_skid_v) begin
            r_out <= r_skid;
        end
    end

    assign o_tvalid      = r_out_v;
    assign o_tdata       = r_out;
    assign o_stat.out_v  = r_out_v;
    assign o_stat.skid_v = r_skid_v;

endmodule

`default_nettype wire

// ----- design/stereo_feedforward_echo.sv -----
// Top level of the stereo feedforward echo: config registers, delay-line
// addressing, two channel lanes and the output merge. Depends on sfe_pkg,
// sfe_lane, sfe_out and assert_macros.svh.
//
//  channel  direction  handshake                 payload
//  s_axis   in         s_axis_tvalid/tready      tdata {right_in, left_in}, tuser action
//  m_axis   out        m_axis_tvalid/tready      tdata {right_out, left_out}
//  cfg      in         i_cfg_valid/o_cfg_ready   i_cfg_index, i_cfg_data
//
// One stereo pair per cycle while the skid stage is empty; m_axis_tvalid
// follows the input transfer through three register stages: RAM read at the
// transfer edge, multiply, add/saturate into the output register.
// The delay-line RAM port and the 16x17 multiply in each lane set this pace.
// Reset clears write position, fill count and registers; the delay lines
// are not cleared, the fill count keeps unwritten entries out of the sum.
// A stalled output fills the skid stage, then input tready drops.
`default_nettype none
`include "assert_macros.svh"

module stereo_feedforward_echo #(
    parameter int MAX_DELAY = 65536
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // input stream
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [2*sfe_pkg::SAMPLE_W-1:0] s_axis_tdata,  // [15:0] left_in, [31:16] right_in
    input  wire logic                          s_axis_tuser,  // [0] action
    // output stream
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [2*sfe_pkg::SAMPLE_W-1:0]     m_axis_tdata,  // [15:0] left_out, [31:16] right_out
    // configuration writes
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [sfe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [sfe_pkg::DELAY_W-1:0]   i_cfg_data
);
    import sfe_pkg::*;

    localparam int AW = $clog2(MAX_DELAY);
    localparam int FW = $clog2(MAX_DELAY + 1);
    localparam int CW = (FW > DELAY_W) ? FW : DELAY_W;
    localparam logic [CW-1:0] MAX_C  = CW'(MAX_DELAY);
    localparam logic [AW-1:0] LAST_A = AW'(MAX_DELAY - 1);
    localparam logic [FW-1:0] MAX_F  = FW'(MAX_DELAY);

    logic [DELAY_W-1:0] r_delay;
    logic [GAIN_W-1:0]  r_gain;
    logic [AW-1:0]      r_wp, n_wp;
    logic [FW-1:0]      r_fill, n_fill;
    logic               r_v1, r_v2;

    logic [CW-1:0]      d_raw, d_c;
    logic [CW:0]        diff;
    logic [AW-1:0]      rd_addr;
    logic               en, accept, push;
    t_lane_ctl          lane_ctl;
    t_out_stat          out_stat;
    logic signed [SAMPLE_W-1:0] left_s, right_s, left_r, right_r;

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= DELAY_RESET;
            r_gain  <= GAIN_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_DELAY: r_delay <= i_cfg_data;
                REG_GAIN:  r_gain  <= i_cfg_data[GAIN_W-1:0];
                default:   ;
            endcase
        end
    end

    // effective delay: zero means one, clamp to line length
    always_comb begin
        d_raw = (r_delay == '0) ? CW'(1) : CW'(r_delay);
        d_c   = (d_raw > MAX_C) ? MAX_C : d_raw;
    end

    assign diff    = {1'b0, CW'(r_wp)} - {1'b0, d_c};
    assign rd_addr = diff[CW] ? AW'(diff + (CW+1)'(MAX_DELAY)) : diff[AW-1:0];

    // pipeline control
    assign en            = ~out_stat.skid_v;
    assign s_axis_tready = en;
    assign accept        = s_axis_tvalid & en;
    assign push          = r_v2 & en;

    assign lane_ctl.en     = en;
    assign lane_ctl.load   = accept;
    assign lane_ctl.active = CW'(r_fill) >= d_c;

    always_comb begin
        n_wp   = (r_wp == LAST_A) ? '0 : r_wp + AW'(1);
        n_fill = (r_fill < MAX_F) ? r_fill + FW'(1) : r_fill;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_fill <= '0;
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
        end else begin
            if (accept) begin
                r_wp   <= n_wp;
                r_fill <= n_fill;
            end
            if (en) begin
                r_v1 <= accept;
                r_v2 <= r_v1;
            end
        end
    end

    // tail tick feeds a zero pair into the lines
    assign left_s  = (s_axis_tuser == ACT_TAIL) ? '0 : s_axis_tdata[SAMPLE_W-1:0];
    assign right_s = (s_axis_tuser == ACT_TAIL) ? '0 : s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];

    sfe_lane #(.DEPTH(MAX_DELAY)) u_left (
        .i_clk     (i_clk),
        .i_ctl     (lane_ctl),
        .i_wr_addr (r_wp),
        .i_rd_addr (rd_addr),
        .i_sample  (left_s),
        .i_gain    (r_gain),
        .o_result  (left_r)
    );

    sfe_lane #(.DEPTH(MAX_DELAY)) u_right (
        .i_clk     (i_clk),
        .i_ctl     (lane_ctl),
        .i_wr_addr (r_wp),
        .i_rd_addr (rd_addr),
        .i_sample  (right_s),
        .i_gain    (r_gain),
        .o_result  (right_r)
    );

    sfe_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_left   (left_r),
        .i_right  (right_r),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_tdata  (m_axis_tdata),
        .o_stat   (out_stat)
    );

    // checks
    `SFE_ASSERT(a_skid_behind_out, i_clk, i_rst_n, out_stat.skid_v |-> out_stat.out_v)
    `SFE_NEVER(a_no_accept_skid_full, i_clk, i_rst_n, accept && out_stat.skid_v)
    `SFE_ASSERT(a_fill_bounded, i_clk, i_rst_n, r_fill <= MAX_F)
    `SFE_ASSERT(a_wp_steps, i_clk, i_rst_n,
        accept |=> (r_wp == (($past(r_wp) == LAST_A) ? '0 : $past(r_wp) + AW'(1))))

endmodule

`default_nettype wire

// ----- verif/echo_checker.sv -----
`timescale 1ns / 100ps
// Checker for the stereo echo block: watches the input, output and config
// channels, predicts every stereo result and compares. Depends on sfe_pkg.
module echo_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [31:0] i_in_data,   // [15:0] left_in, [31:16] right_in
    input  logic        i_in_user,   // [0] action
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_data,  // [15:0] left_out, [31:16] right_out
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [sfe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sfe_pkg::DELAY_W-1:0]   i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    import sfe_pkg::*;

    localparam int MAX_DELAY  = 65536;

    typedef struct packed {
        logic [SAMPLE_W-1:0] left;
        logic [SAMPLE_W-1:0] right;
    } t_stereo;

    logic [SAMPLE_W-1:0] left_hist  [MAX_DELAY];
    logic [SAMPLE_W-1:0] right_hist [MAX_DELAY];
    int                  wr_pos;
    int                  seen_count;
    logic [DELAY_W-1:0]  delay_reg;
    logic [GAIN_W-1:0]   gain_reg;
    t_stereo             due_pairs[$];
    int                  mismatches = 0;

    // Dry sample plus floor-shifted echo term, saturated to 16 bits.
    function automatic logic [SAMPLE_W-1:0] echo_mix(input logic signed [SAMPLE_W-1:0] dry,
                                                     input logic signed [SAMPLE_W-1:0] past,
                                                     input logic echo_on,
                                                     input logic [GAIN_W-1:0] gain);
        logic signed [GAIN_W:0]  g;
        logic signed [33:0]      scaled;
        logic signed [33:0]      total;
        g      = {1'b0, gain};
        scaled = 34'(past) * 34'(g);
        total  = 34'(dry);
        if (echo_on)
            total = total + (scaled >>> FRAC_BITS);
        if (total > 32767)
            return 16'h7fff;
        if (total < -32768)
            return 16'h8000;
        return total[SAMPLE_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] want,
                                   input logic [SAMPLE_W-1:0] got);
        mismatches++;
        $display("%0t echo_checker: %s expected %0d got %0d", $time, what,
                 $signed(want), $signed(got));
    endtask

    always @(posedge i_clk) begin
        int                  eff;
        int                  rd;
        logic                echo_on;
        logic [SAMPLE_W-1:0] dry_l;
        logic [SAMPLE_W-1:0] dry_r;
        t_stereo             want;
        if (!i_rst_n) begin
            wr_pos     = 0;
            seen_count = 0;
            delay_reg  = DELAY_RESET;
            gain_reg   = GAIN_RESET;
            due_pairs.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_DELAY: delay_reg = i_cfg_data;
                    REG_GAIN:  gain_reg  = i_cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end

            if (i_out_valid && i_out_ready) begin
                if (due_pairs.size() == 0) begin
                    report_mismatch("result with nothing pending, left", '0,
                                    i_out_data[15:0]);
                end else begin
                    want = due_pairs.pop_front();
                    if (i_out_data[15:0] !== want.left)
                        report_mismatch("left_out", want.left, i_out_data[15:0]);
                    if (i_out_data[31:16] !== want.right)
                        report_mismatch("right_out", want.right, i_out_data[31:16]);
                end
            end

            if (i_in_valid && i_in_ready) begin
                // zero delay acts as one, anything past the line length as the full line
                eff = (delay_reg == 0) ? 1 : ((delay_reg > MAX_DELAY) ? MAX_DELAY
                                                                      : int'(delay_reg));
                rd      = (wr_pos + MAX_DELAY - eff) % MAX_DELAY;
                echo_on = (seen_count >= eff);
                if (i_in_user == ACT_TAIL) begin
                    dry_l = '0;
                    dry_r = '0;
                end else begin
                    dry_l = i_in_data[15:0];
                    dry_r = i_in_data[31:16];
                end
                want.left  = echo_mix(dry_l, left_hist[rd], echo_on, gain_reg);
                want.right = echo_mix(dry_r, right_hist[rd], echo_on, gain_reg);
                due_pairs.push_back(want);
                left_hist[wr_pos]  = dry_l;
                right_hist[wr_pos] = dry_r;
                wr_pos = (wr_pos + 1) % MAX_DELAY;
                if (seen_count < MAX_DELAY)
                    seen_count++;
            end
        end
        o_pending    <= due_pairs.size();
        o_fail_count <= mismatches;
    end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench top for stereo_feedforward_echo: clock, reset, stimulus and
// verdict. Depends on sfe_pkg, the block itself and echo_checker.
module tb_top;
    import sfe_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 10;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;  // [15:0] left_in, [31:16] right_in
    logic        s_axis_tuser  = ACT_SAMPLE;  // [0] action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;  // [15:0] left_out, [31:16] right_out
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = REG_DELAY;
    logic [DELAY_W-1:0]   i_cfg_data  = '0;

    logic        calm     = 1'b0;  // no idling on either side
    logic        hold_req = 1'b0;
    int          fail_count;
    int          pending;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    stereo_feedforward_echo i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    echo_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_user    (s_axis_tuser),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // One stereo transfer, optionally preceded by a burst of idle cycles.
    task automatic push_item(input logic act, input logic [15:0] l, input logic [15:0] r);
        if (!calm && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {r, l};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_mix(input int count);
        logic [15:0] l;
        logic [15:0] r;
        logic        act;
        int          pick;
        for (int k = 0; k < count; k++) begin
            pick = $urandom_range(0, 15);
            l    = 16'($urandom);
            r    = 16'($urandom);
            act  = ACT_SAMPLE;
            if (pick == 0) begin
                act = ACT_TAIL;  // payload left random: must be ignored
            end else if (pick == 1) begin
                l = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
                r = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
            end else if (pick == 2) begin
                l = {{13{l[15]}}, l[2:0]};
                r = {{13{r[15]}}, r[2:0]};
            end
            push_item(act, l, r);
        end
    endtask

    // Drop valid after the last transfer and wait for every result.
    task automatic finish_phase();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [DELAY_W-1:0] delay, input logic [DELAY_W-1:0] gain_word);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_DELAY;
        i_cfg_data  <= delay;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= REG_GAIN;
        i_cfg_data  <= gain_word;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Output side: random stalls, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req      <= 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [DELAY_W-1:0] delay;
        logic [DELAY_W-1:0] gain_word;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: delay far away, so plain pass-through
        push_item(ACT_SAMPLE, 16'h7fff, 16'h8000);
        push_item(ACT_TAIL,   16'h1234, 16'habcd);
        push_item(ACT_SAMPLE, 16'hffff, 16'h0001);
        push_item(ACT_SAMPLE, 16'h0000, 16'h0000);
        finish_phase();

        // one-sample delay, maximum gain: saturation both ways
        set_config(17'd1, 17'd65535);
        push_item(ACT_SAMPLE, 16'h7fff, 16'h8000);
        push_item(ACT_SAMPLE, 16'h7fff, 16'h8000);
        push_item(ACT_SAMPLE, 16'h8000, 16'h7fff);
        push_item(ACT_SAMPLE, 16'h7fff, 16'h8000);
        push_item(ACT_TAIL,   16'h5555, 16'haaaa);
        push_item(ACT_TAIL,   16'hffff, 16'hffff);
        push_item(ACT_SAMPLE, 16'h0001, 16'hffff);
        finish_phase();

        // zero delay acts as one; floor rounding of a negative echo
        set_config(17'd0, 17'd2048);
        push_item(ACT_SAMPLE, 16'hffff, 16'h0001);
        push_item(ACT_SAMPLE, 16'h0000, 16'h0000);
        push_item(ACT_SAMPLE, 16'hffff, 16'h8000);
        push_item(ACT_TAIL,   16'h0000, 16'h0000);
        finish_phase();

        // zero gain
        set_config(17'd2, 17'd0);
        push_item(ACT_SAMPLE, 16'h7fff, 16'h8000);
        push_item(ACT_SAMPLE, 16'h0001, 16'h0001);
        push_item(ACT_SAMPLE, 16'h7fff, 16'h8000);
        finish_phase();

        for (int p = 0; p < 12; p++) begin
            case (p % 4)
                0: delay = DELAY_W'($urandom_range(1, 16));
                1: delay = DELAY_W'($urandom_range(17, 300));
                2: delay = DELAY_W'($urandom_range(300, 2500));  // can lie past the fill level
                default: begin
                    case ($urandom_range(0, 3))
                        0: delay = 17'd0;
                        1: delay = 17'd1;
                        2: delay = 17'd65536;
                        default: delay = 17'd131071;
                    endcase
                end
            endcase
            case ($urandom_range(0, 3))
                0: gain_word = 17'd0;
                1: gain_word = 17'd65535;
                default: gain_word = DELAY_W'($urandom_range(0, 65535));
            endcase
            gain_word[16] = 1'($urandom_range(0, 1));  // above the gain width
            set_config(delay, gain_word);
            if (p == 5) begin
                calm     <= 1'b1;
                hold_req <= 1'b1;
            end
            send_mix(120);
            finish_phase();
            calm <= 1'b0;
        end

        // delay above the line length: clamped to the full line
        set_config(17'd131071, DELAY_W'($urandom_range(0, 65535)));
        send_mix(64);
        finish_phase();

        calm <= 1'b1;
        set_config(17'd65536, 17'd4096);
        send_mix(100);
        finish_phase();
        set_config(17'd1, 17'd65535);
        send_mix(100);
        finish_phase();
        set_config(17'd0, DELAY_W'($urandom_range(0, 65535)));
        send_mix(50);
        finish_phase();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
